// ===== hw/rtl/rsfl_pkg.sv =====
// shared types and constants for the record store with in-place free list
// no dependencies; used by rsfl_ctrl, rsfl_dp and record_store_free_list
package rsfl_pkg;

  localparam int IndexW  = 10;
  localparam int LinkW   = 11;
  localparam int RecordW = 64;

  localparam logic [LinkW-1:0] NullLink = 11'd2047;

  // operation codes carried in the kind field
  localparam logic [1:0] KindAdd    = 2'd0;
  localparam logic [1:0] KindGet    = 2'd1;
  localparam logic [1:0] KindDelete = 2'd2;

  // result status codes
  localparam logic [1:0] StatusOk       = 2'd0;
  localparam logic [1:0] StatusBadIndex = 2'd1;
  localparam logic [1:0] StatusFull     = 2'd2;

  typedef struct packed {
    logic [1:0]         kind;
    logic [IndexW-1:0]  slot_index;
    logic [RecordW-1:0] record_data;
  } in_item_t;

  typedef struct packed {
    logic [IndexW-1:0]  result_index;
    logic [RecordW-1:0] result_record;
    logic [1:0]         status;
  } out_item_t;

  // controller to datapath
  typedef struct packed {
    logic capture;
    logic commit;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic out_free;
  } dp_sts_t;

endpackage

// ===== hw/rtl/rsfl_ctrl.sv =====
// controller for the record store: accepts a word, waits for the slot read,
// then commits once the output register is free; uses rsfl_pkg
module rsfl_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  rsfl_pkg::dp_sts_t sts_i,
  output rsfl_pkg::dp_cmd_t cmd_o
);

  typedef enum logic [1:0] {
    StIdle = 2'b01,
    StBusy = 2'b10
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    cmd_o.capture = 1'b0;
    cmd_o.commit  = 1'b0;
    state_d       = state_q;
    case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = StBusy;
        end
      end
      StBusy: begin
        // slot read is back; finish when the result can be stored
        if (sts_i.out_free) begin
          cmd_o.commit = 1'b1;
          state_d      = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  assign in_stall_o = (state_q != StIdle);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== hw/rtl/rsfl_dp.sv =====
// datapath for the record store: slot memory, free list head, end count,
// item registers and the output register; uses rsfl_pkg
module rsfl_dp #(
  parameter int DEPTH        = 1024,
  parameter int RECORD_WIDTH = 64
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  rsfl_pkg::in_item_t  in_item_i,
  input  rsfl_pkg::dp_cmd_t   cmd_i,
  output rsfl_pkg::dp_sts_t   sts_o,
  input  logic                out_stall_i,
  output logic                out_valid_o,
  output rsfl_pkg::out_item_t out_item_o
);

  localparam int AddrW = $clog2(DEPTH);
  localparam logic [rsfl_pkg::LinkW-1:0] DepthL = rsfl_pkg::LinkW'(DEPTH);

  logic [RECORD_WIDTH-1:0] mem_q [DEPTH];

  logic [rsfl_pkg::LinkW-1:0]   free_head_q, free_head_d;
  logic [rsfl_pkg::LinkW-1:0]   used_end_q, used_end_d;
  logic                         out_valid_q, out_valid_d;
  logic [1:0]                   kind_q;
  logic [rsfl_pkg::IndexW-1:0]  idx_q;
  logic [RECORD_WIDTH-1:0]      data_q;
  logic [RECORD_WIDTH-1:0]      rd_data_q;
  rsfl_pkg::out_item_t          out_item_q, out_item_d;

  logic [AddrW-1:0]             rd_addr;
  logic                         wr_en;
  logic [AddrW-1:0]             wr_addr;
  logic [RECORD_WIDTH-1:0]      wr_data;
  logic                         head_valid;
  logic                         has_room;
  logic                         bad_index;
  logic [rsfl_pkg::LinkW-1:0]   idx_ext;
  logic [rsfl_pkg::LinkW-1:0]   link;

  assign sts_o.out_free = !out_valid_q || !out_stall_i;

  // add reads the head slot for its link, get reads the addressed slot
  assign rd_addr = (in_item_i.kind == rsfl_pkg::KindAdd) ? free_head_q[AddrW-1:0]
                                                         : in_item_i.slot_index[AddrW-1:0];

  assign idx_ext    = {1'b0, idx_q};
  assign link       = rd_data_q[rsfl_pkg::LinkW-1:0];
  assign head_valid = (free_head_q != rsfl_pkg::NullLink) && (free_head_q < used_end_q);
  assign has_room   = used_end_q < DepthL;
  assign bad_index  = (idx_ext >= used_end_q) || (idx_ext >= DepthL);

  always_comb begin
    free_head_d              = free_head_q;
    used_end_d               = used_end_q;
    wr_en                    = 1'b0;
    wr_addr                  = idx_q[AddrW-1:0];
    wr_data                  = data_q;
    out_item_d.result_index  = idx_q;
    out_item_d.result_record = '0;
    out_item_d.status        = rsfl_pkg::StatusOk;
    case (kind_q)
      rsfl_pkg::KindAdd: begin
        if (head_valid) begin
          // a link at or past the end count empties the list
          free_head_d             = (link < used_end_q) ? link : rsfl_pkg::NullLink;
          wr_en                   = 1'b1;
          wr_addr                 = free_head_q[AddrW-1:0];
          out_item_d.result_index = free_head_q[rsfl_pkg::IndexW-1:0];
        end else if (has_room) begin
          used_end_d              = used_end_q + rsfl_pkg::LinkW'(1);
          wr_en                   = 1'b1;
          wr_addr                 = used_end_q[AddrW-1:0];
          out_item_d.result_index = used_end_q[rsfl_pkg::IndexW-1:0];
        end else begin
          out_item_d.status       = rsfl_pkg::StatusFull;
          out_item_d.result_index = '0;
        end
      end
      rsfl_pkg::KindGet: begin
        if (bad_index) begin
          out_item_d.status = rsfl_pkg::StatusBadIndex;
        end else begin
          out_item_d.result_record = rsfl_pkg::RecordW'(rd_data_q);
        end
      end
      rsfl_pkg::KindDelete: begin
        if (bad_index) begin
          out_item_d.status = rsfl_pkg::StatusBadIndex;
        end else begin
          wr_en       = 1'b1;
          wr_data     = RECORD_WIDTH'(free_head_q);
          free_head_d = idx_ext;
        end
      end
      default: begin
      end
    endcase
  end

  assign out_valid_d = cmd_i.commit || (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      free_head_q <= rsfl_pkg::NullLink;
      used_end_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (cmd_i.commit) begin
        free_head_q <= free_head_d;
        used_end_q  <= used_end_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      kind_q    <= in_item_i.kind;
      idx_q     <= in_item_i.slot_index;
      data_q    <= in_item_i.record_data[RECORD_WIDTH-1:0];
      rd_data_q <= mem_q[rd_addr];
    end
    if (cmd_i.commit && wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
    if (cmd_i.commit) begin
      out_item_q <= out_item_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule

// ===== hw/rtl/record_store_free_list.sv =====
// record store with in-place free list: add, get and delete of fixed slots
// the slot is read into a register at the accepting edge, and the result
// commits to the output register once that register is free; a new word
// is taken only after the current one commits, as the registered read of
// the slot memory must return before the head and end count can update
// reset: free list empty, end count zero, slot memory not cleared
module record_store_free_list #(
  parameter int DEPTH        = 1024,
  parameter int RECORD_WIDTH = 64
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  rsfl_pkg::in_item_t  in_item_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output rsfl_pkg::out_item_t out_item_o
);

  rsfl_pkg::dp_cmd_t cmd;
  rsfl_pkg::dp_sts_t sts;

  rsfl_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  rsfl_dp #(
    .DEPTH        (DEPTH),
    .RECORD_WIDTH (RECORD_WIDTH)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_item_i   (in_item_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_item_o  (out_item_o)
  );

endmodule
